>>> design/loc_pkg.sv
// ----------------------------------------------------------------------------
// loc_pkg: lock-order checker types and codes
// Event and result payloads, request codes and lock kind codes.
// ----------------------------------------------------------------------------
package loc_pkg;

  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_ACQUIRE  = 2'd1;
  localparam logic [1:0] REQ_RELEASE  = 2'd2;
  localparam logic [1:0] REQ_ASSERT   = 2'd3;

  localparam logic [1:0] KIND_SLEEP = 2'd0;
  localparam logic [1:0] KIND_SPIN  = 2'd1;
  localparam logic [1:0] KIND_IRQ   = 2'd2;

  localparam logic [16:0] EDGE_MAX = 17'h1FFFF;
  localparam logic [4:0]  HITS_MAX = 5'd31;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] cpu_index;
    logic [7:0] lock_class;
    logic [1:0] lock_kind;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  inversion_hits;
    logic [7:0]  inverted_with;
    logic        kind_cross;
    logic [7:0]  kind_offender;
    logic        stack_overflow;
    logic        release_unmatched;
    logic        assert_missing;
    logic [4:0]  held_depth;
    logic        halt_request;
    logic [63:0] inversions_total;
    logic [16:0] edges_total;
    logic [63:0] kind_violations_total;
  } out_item_t;

endpackage

>>> design/lock_order_checker_core.sv
// ----------------------------------------------------------------------------
// lock_order_checker_core: lock-order validator
// Tracks held lock classes per CPU, records order edges in a bit matrix and
// flags order inversions, sleep-under-spin or sleep-under-irq acquisitions and stack misuse.
// ----------------------------------------------------------------------------
// One event is taken at a time and produces one result. After reset a
// clearing pass over all CLASS_COUNT*ceil(CLASS_COUNT/64) matrix words (1024
// at the default size) zeroes the order matrix and the class kinds; no event
// is taken then. For acquire, each held entry other than the new class
// itself costs a stack read, a kind read, a matrix read-modify-write of the
// held->new word and a matrix read of the new->held word. Release and
// assert-held scan the stack top down, and release then closes the gap by
// moving each entry above the match down one place.
// The result register lets the next event in while a result waits.
module lock_order_checker_core
  import loc_pkg::*;
#(
  parameter int CLASS_COUNT = 256,
  parameter int HELD_DEPTH  = 16,
  parameter int CPU_COUNT   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int ROW_WORDS = (CLASS_COUNT + 63) / 64;
  localparam int MAT_WORDS = CLASS_COUNT * ROW_WORDS;
  localparam int MA = (MAT_WORDS > 1) ? $clog2(MAT_WORDS) : 1;
  localparam int KA = $clog2(CLASS_COUNT);
  localparam int STK_WORDS = CPU_COUNT * HELD_DEPTH;
  localparam int SA = (STK_WORDS > 1) ? $clog2(STK_WORDS) : 1;
  localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int DW = $clog2(HELD_DEPTH + 1);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_KIND  = 13'b0000000000100,
    S_ARD   = 13'b0000000001000,
    S_AH    = 13'b0000000010000,
    S_AW    = 13'b0000000100000,
    S_AC    = 13'b0000001000000,
    S_PUSH  = 13'b0000010000000,
    S_SRD   = 13'b0000100000000,
    S_SCHK  = 13'b0001000000000,
    S_SHRD  = 13'b0010000000000,
    S_SHWR  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  // memories
  logic [63:0] mat_mem [MAT_WORDS];
  logic [1:0]  kind_mem [CLASS_COUNT];
  logic [7:0]  stk_mem [STK_WORDS];

  logic [63:0] mat_q;
  logic [1:0]  kind_q;
  logic [7:0]  stk_q;

  logic [MA-1:0] mat_raddr, mat_waddr;
  logic [63:0]   mat_wdata;
  logic          mat_we;
  logic [KA-1:0] kind_raddr, kind_waddr;
  logic [1:0]    kind_wdata;
  logic          kind_we;
  logic [SA-1:0] stk_raddr, stk_waddr;
  logic [7:0]    stk_wdata;
  logic          stk_we;

  state_t state_r, state_nxt;
  logic [MA-1:0] clr_r, clr_nxt;
  logic [DW-1:0] held_cnt_r [CPU_COUNT];
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] idx_r, idx_nxt;
  logic [1:0]    req_r, req_nxt;
  logic [CW-1:0] cpu_r, cpu_nxt;
  logic [7:0]    cls_r, cls_nxt;
  logic [7:0]    h_r, h_nxt;
  logic          new_sleep_r, new_sleep_nxt;
  logic [4:0]    hits_r, hits_nxt;
  logic [7:0]    inv_with_r, inv_with_nxt;
  logic          cross_r, cross_nxt;
  logic [7:0]    offender_r, offender_nxt;
  logic          ovf_r, ovf_nxt;
  logic          unmatched_r, unmatched_nxt;
  logic          missing_r, missing_nxt;
  logic [63:0]   inv_cnt_r, inv_cnt_nxt;
  logic [16:0]   edge_cnt_r, edge_cnt_nxt;
  logic [63:0]   kind_cnt_r, kind_cnt_nxt;
  logic          halt_en_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic          in_xfer;
  logic          out_free;
  logic [CW-1:0] in_cpu;
  logic          in_cls_ok;

  function automatic logic [MA-1:0] mat_addr(input logic [7:0] row, input logic [7:0] col);
    return MA'(int'(row) * ROW_WORDS + int'(col >> 6));
  endfunction

  function automatic logic [SA-1:0] stk_addr(input logic [CW-1:0] cpu,
                                             input logic [DW-1:0] idx);
    return SA'(int'(cpu) * HELD_DEPTH + int'(idx));
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_cpu    = (int'(in_data.cpu_index) < CPU_COUNT) ? CW'(in_data.cpu_index) : '0;
  assign in_cls_ok = (in_data.lock_class != 8'd0) && (int'(in_data.lock_class) < CLASS_COUNT);

  always_ff @(posedge clk) begin
    mat_q  <= mat_mem[mat_raddr];
    kind_q <= kind_mem[kind_raddr];
    stk_q  <= stk_mem[stk_raddr];
    if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
    if (kind_we) kind_mem[kind_waddr] <= kind_wdata;
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    depth_nxt     = depth_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    cpu_nxt       = cpu_r;
    cls_nxt       = cls_r;
    h_nxt         = h_r;
    new_sleep_nxt = new_sleep_r;
    hits_nxt      = hits_r;
    inv_with_nxt  = inv_with_r;
    cross_nxt     = cross_r;
    offender_nxt  = offender_r;
    ovf_nxt       = ovf_r;
    unmatched_nxt = unmatched_r;
    missing_nxt   = missing_r;
    inv_cnt_nxt   = inv_cnt_r;
    edge_cnt_nxt  = edge_cnt_r;
    kind_cnt_nxt  = kind_cnt_r;

    mat_raddr  = mat_addr(h_r, cls_r);
    mat_waddr  = mat_addr(h_r, cls_r);
    mat_wdata  = mat_q;
    mat_we     = 1'b0;
    kind_raddr = KA'(in_data.lock_class);
    kind_waddr = KA'(in_data.lock_class);
    kind_wdata = in_data.lock_kind;
    kind_we    = 1'b0;
    stk_raddr  = stk_addr(cpu_r, idx_r);
    stk_waddr  = stk_addr(cpu_r, depth_r);
    stk_wdata  = cls_r;
    stk_we     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mat_waddr  = clr_r;
        mat_wdata  = '0;
        mat_we     = 1'b1;
        kind_waddr = KA'(clr_r);
        kind_wdata = KIND_SLEEP;
        kind_we    = (int'(clr_r) < CLASS_COUNT);
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == MA'(MAT_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt       = in_data.req_type;
          cpu_nxt       = in_cpu;
          cls_nxt       = in_data.lock_class;
          depth_nxt     = held_cnt_r[in_cpu];
          hits_nxt      = '0;
          inv_with_nxt  = '0;
          cross_nxt     = 1'b0;
          offender_nxt  = '0;
          ovf_nxt       = 1'b0;
          unmatched_nxt = 1'b0;
          missing_nxt   = 1'b0;
          idx_nxt       = '0;
          if (!in_cls_ok) begin
            state_nxt = S_DONE;
          end else begin
            unique case (in_data.req_type)
              REQ_REGISTER: begin
                kind_we   = 1'b1;
                state_nxt = S_DONE;
              end
              REQ_ACQUIRE: state_nxt = S_KIND;
              default: begin
                idx_nxt = held_cnt_r[in_cpu];
                if (held_cnt_r[in_cpu] == '0) begin
                  unmatched_nxt = (in_data.req_type == REQ_RELEASE);
                  missing_nxt   = (in_data.req_type == REQ_ASSERT);
                  state_nxt     = S_DONE;
                end else begin
                  state_nxt = S_SRD;
                end
              end
            endcase
          end
        end
      end
      S_KIND: begin
        new_sleep_nxt = (kind_q == KIND_SLEEP);
        state_nxt     = (depth_r == '0) ? S_PUSH : S_ARD;
      end
      S_ARD: begin
        state_nxt = S_AH;
      end
      S_AH: begin
        // stack data is back: fetch the held->new word and the held kind
        h_nxt      = stk_q;
        mat_raddr  = mat_addr(stk_q, cls_r);
        kind_raddr = KA'(stk_q);
        if (stk_q == cls_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (idx_r + 1'b1 == depth_r) ? S_PUSH : S_ARD;
        end else begin
          state_nxt = S_AW;
        end
      end
      S_AW: begin
        if (!mat_q[cls_r[5:0]]) begin
          mat_we = 1'b1;
          mat_wdata[cls_r[5:0]] = 1'b1;
          if (edge_cnt_r != EDGE_MAX) edge_cnt_nxt = edge_cnt_r + 1'b1;
        end
        if (new_sleep_r && !cross_r && (kind_q == KIND_SPIN || kind_q == KIND_IRQ)) begin
          cross_nxt    = 1'b1;
          offender_nxt = h_r;
          if (kind_cnt_r != '1) kind_cnt_nxt = kind_cnt_r + 1'b1;
        end
        mat_raddr = mat_addr(cls_r, h_r);
        state_nxt = S_AC;
      end
      S_AC: begin
        if (mat_q[h_r[5:0]]) begin
          if (inv_cnt_r != '1) inv_cnt_nxt = inv_cnt_r + 1'b1;
          if (hits_r == '0) inv_with_nxt = h_r;
          if (hits_r != HITS_MAX) hits_nxt = hits_r + 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = (idx_r + 1'b1 == depth_r) ? S_PUSH : S_ARD;
      end
      S_PUSH: begin
        if (int'(depth_r) < HELD_DEPTH) begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SRD: begin
        // top-down scan, idx holds one above the entry being read
        stk_raddr = stk_addr(cpu_r, idx_r - 1'b1);
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (stk_q == cls_r) begin
          if (req_r == REQ_RELEASE) begin
            if (idx_r + 1'b1 < depth_r) begin
              state_nxt = S_SHRD;
            end else begin
              depth_nxt = depth_r - 1'b1;
              state_nxt = S_DONE;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end else if (idx_r == '0) begin
          unmatched_nxt = (req_r == REQ_RELEASE);
          missing_nxt   = (req_r == REQ_ASSERT);
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SHRD: begin
        stk_raddr = stk_addr(cpu_r, idx_r + 1'b1);
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        stk_waddr = stk_addr(cpu_r, idx_r);
        stk_wdata = stk_q;
        stk_we    = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r + 2'd2 < {1'b0, depth_r}) begin
          state_nxt = S_SHRD;
        end else begin
          depth_nxt = depth_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      inv_cnt_r   <= '0;
      edge_cnt_r  <= '0;
      kind_cnt_r  <= '0;
      halt_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CPU_COUNT; c++) held_cnt_r[c] <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      inv_cnt_r  <= inv_cnt_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      kind_cnt_r <= kind_cnt_nxt;
      if (cfg_wr_en) halt_en_r <= cfg_wr_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == S_DONE && out_free) begin
        out_valid_r        <= 1'b1;
        held_cnt_r[cpu_r]  <= depth_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    depth_r     <= depth_nxt;
    idx_r       <= idx_nxt;
    req_r       <= req_nxt;
    cpu_r       <= cpu_nxt;
    cls_r       <= cls_nxt;
    h_r         <= h_nxt;
    new_sleep_r <= new_sleep_nxt;
    hits_r      <= hits_nxt;
    inv_with_r  <= inv_with_nxt;
    cross_r     <= cross_nxt;
    offender_r  <= offender_nxt;
    ovf_r       <= ovf_nxt;
    unmatched_r <= unmatched_nxt;
    missing_r   <= missing_nxt;
    if (state_r == S_DONE && out_free) begin
      out_data_r.inversion_hits        <= hits_r;
      out_data_r.inverted_with         <= inv_with_r;
      out_data_r.kind_cross            <= cross_r;
      out_data_r.kind_offender         <= offender_r;
      out_data_r.stack_overflow        <= ovf_r;
      out_data_r.release_unmatched     <= unmatched_r;
      out_data_r.assert_missing        <= missing_r;
      out_data_r.held_depth            <= (int'(depth_r) > 31) ? 5'd31 : 5'(depth_r);
      out_data_r.halt_request          <= (hits_r != '0) && halt_en_r;
      out_data_r.inversions_total      <= inv_cnt_r;
      out_data_r.edges_total           <= edge_cnt_r;
      out_data_r.kind_violations_total <= kind_cnt_r;
    end
  end

endmodule
